// ===== rtl/core/sle_pkg.sv =====
package sle_pkg;

    localparam int SCAN_W = 8;
    localparam int CHAR_W = 7;
    localparam int POS_W  = 6;
    localparam int KIND_W = 2;
    localparam int CFG_W  = 7;

    localparam int BREAK_BIT = 7;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 7'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 7'h0A;

    localparam logic [KIND_W-1:0] KIND_ECHO      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERASE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LINE_CHAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LINE_END  = 2'd3;

    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_BACKSPACE,
        OP_ENTER
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_EMIT,
        BK_END
    } back_state_t;

    // set-1 make code to ascii, zero for keys with no character
    function automatic logic [CHAR_W-1:0] key_ascii(input logic [6:0] code);
        logic [CHAR_W-1:0] c;
        case (code)
            7'd1:    c = 7'h1B;
            7'd2:    c = 7'h31;
            7'd3:    c = 7'h32;
            7'd4:    c = 7'h33;
            7'd5:    c = 7'h34;
            7'd6:    c = 7'h35;
            7'd7:    c = 7'h36;
            7'd8:    c = 7'h37;
            7'd9:    c = 7'h38;
            7'd10:   c = 7'h39;
            7'd11:   c = 7'h30;
            7'd12:   c = 7'h2D;
            7'd13:   c = 7'h3D;
            7'd14:   c = 7'h08;
            7'd15:   c = 7'h09;
            7'd16:   c = 7'h71;
            7'd17:   c = 7'h77;
            7'd18:   c = 7'h65;
            7'd19:   c = 7'h72;
            7'd20:   c = 7'h74;
            7'd21:   c = 7'h79;
            7'd22:   c = 7'h75;
            7'd23:   c = 7'h69;
            7'd24:   c = 7'h6F;
            7'd25:   c = 7'h70;
            7'd26:   c = 7'h5B;
            7'd27:   c = 7'h5D;
            7'd28:   c = 7'h0A;
            7'd30:   c = 7'h61;
            7'd31:   c = 7'h73;
            7'd32:   c = 7'h64;
            7'd33:   c = 7'h66;
            7'd34:   c = 7'h67;
            7'd35:   c = 7'h68;
            7'd36:   c = 7'h6A;
            7'd37:   c = 7'h6B;
            7'd38:   c = 7'h6C;
            7'd39:   c = 7'h3B;
            7'd40:   c = 7'h27;
            7'd41:   c = 7'h60;
            7'd43:   c = 7'h5C;
            7'd44:   c = 7'h7A;
            7'd45:   c = 7'h78;
            7'd46:   c = 7'h63;
            7'd47:   c = 7'h76;
            7'd48:   c = 7'h62;
            7'd49:   c = 7'h6E;
            7'd50:   c = 7'h6D;
            7'd51:   c = 7'h2C;
            7'd52:   c = 7'h2E;
            7'd53:   c = 7'h2F;
            7'd55:   c = 7'h2A;
            7'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/sle_front.sv =====
module sle_front (
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [sle_pkg::SCAN_W-1:0] s_axis_tdata,   // scancode
    output logic                       push_valid,
    input  logic                       push_ready,
    output sle_pkg::cmd_t              push_cmd
);
    import sle_pkg::*;

    logic [CHAR_W-1:0] ch;
    logic              is_break;

    assign ch       = key_ascii(s_axis_tdata[6:0]);
    assign is_break = s_axis_tdata[BREAK_BIT];

    // dropped beats are still taken, but only when the queue could take one
    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid && !is_break && (ch != '0);

    always_comb
    begin
        push_cmd.ch = ch;
        if (ch == CH_NEWLINE)
        begin
            push_cmd.op = OP_ENTER;
        end
        else if (ch == CH_BACKSPACE)
        begin
            push_cmd.op = OP_BACKSPACE;
        end
        else
        begin
            push_cmd.op = OP_CHAR;
        end
    end

endmodule

// ===== rtl/core/sle_queue.sv =====
module sle_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  sle_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output sle_pkg::cmd_t pop_cmd
);
    import sle_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/sle_back.sv =====
module sle_back #(
    parameter int LINE_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [sle_pkg::CFG_W-1:0]  max_len,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  sle_pkg::cmd_t              pop_cmd,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // character, position
    output logic [sle_pkg::KIND_W-1:0] m_axis_tuser,   // kind
    output logic                       m_axis_tlast
);
    import sle_pkg::*;

    localparam int ADDR_W = (LINE_DEPTH > 2) ? $clog2(LINE_DEPTH) : 1;
    localparam logic [CFG_W-1:0] DEPTH_C = CFG_W'(LINE_DEPTH);

    logic [CHAR_W-1:0] line_mem [LINE_DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              mem_we;
    logic [CFG_W-1:0]  cap_sat;
    logic [CFG_W-1:0]  capacity;
    logic              line_full;

    assign out_free = !out_valid_reg || m_axis_tready;

    assign cap_sat   = (max_len > DEPTH_C) ? DEPTH_C : max_len;
    assign capacity  = (cap_sat == '0) ? '0 : cap_sat - CFG_W'(1);
    assign line_full = (CFG_W'(len_reg) >= capacity);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[len_reg] <= pop_cmd.ch;
        end
        rd_data_reg <= line_mem[idx_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        pop_ready      = 1'b0;
        mem_we         = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    case (pop_cmd.op)
                        OP_CHAR:
                        begin
                            if (line_full)
                            begin
                                pop_ready = 1'b1;
                            end
                            else if (out_free)
                            begin
                                pop_ready      = 1'b1;
                                mem_we         = 1'b1;
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_ECHO;
                                out_char_next  = pop_cmd.ch;
                                out_pos_next   = POS_W'(len_reg);
                                out_last_next  = 1'b1;
                                len_next       = len_reg + ADDR_W'(1);
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            if (len_reg == '0)
                            begin
                                pop_ready = 1'b1;
                            end
                            else if (out_free)
                            begin
                                pop_ready      = 1'b1;
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_ERASE;
                                out_char_next  = '0;
                                out_pos_next   = POS_W'(len_reg - ADDR_W'(1));
                                out_last_next  = 1'b1;
                                len_next       = len_reg - ADDR_W'(1);
                            end
                        end
                        OP_ENTER:
                        begin
                            pop_ready  = 1'b1;
                            idx_next   = '0;
                            state_next = (len_reg == '0) ? BK_END : BK_FETCH;
                        end
                        default:
                        begin
                            pop_ready = 1'b1;
                        end
                    endcase
                end
            end
            BK_FETCH:
            begin
                // registered read of line_mem[idx] lands this edge
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_LINE_CHAR;
                    out_char_next  = rd_data_reg;
                    out_pos_next   = POS_W'(idx_reg);
                    out_last_next  = 1'b0;
                    if (idx_reg == len_reg - ADDR_W'(1))
                    begin
                        state_next = BK_END;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = BK_FETCH;
                    end
                end
            end
            BK_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_LINE_END;
                    out_char_next  = '0;
                    out_pos_next   = POS_W'(len_reg);
                    out_last_next  = 1'b1;
                    len_next       = '0;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_char_reg <= out_char_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_pos_reg, out_char_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/core/scancode_line_editor.sv =====
// Line editor fed by raw set-1 keyboard scancodes, one byte per input beat.
// Break codes and keys with no character are taken and dropped. A printable
// key is stored and echoed (kind 0) if the line has room, backspace emits an
// erase (kind 1) for the removed position, and enter emits every stored
// character (kind 2) followed by a line-end beat (kind 3, position = length)
// and clears the line. tlast marks the final beat caused by one scancode. The
// front end classifies a scancode in the cycle it is taken and hands it to a
// two-entry queue, so input keeps flowing while the output is stalled until
// the queue is full. The back end takes an ordinary key when the output
// register is free; enter takes the command, fetches each stored character
// through the registered read of the line memory and emits it, then emits
// the line-end beat. The user must write max_len through cfg_wr_en/cfg_wr_data
// only while the block is idle; the block does not enforce it. Values above LINE_DEPTH
// act as LINE_DEPTH; at most max_len - 1 characters are kept, zero keeps none.
module scancode_line_editor #(
    parameter int LINE_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [sle_pkg::CFG_W-1:0]  cfg_wr_data,    // max_len
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [sle_pkg::SCAN_W-1:0] s_axis_tdata,   // scancode[7:0]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // character[6:0], position[12:7]
    output logic [sle_pkg::KIND_W-1:0] m_axis_tuser,   // kind[1:0]
    output logic                       m_axis_tlast
);
    import sle_pkg::*;

    logic [CFG_W-1:0] max_len_reg;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    sle_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    sle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    sle_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .max_len       (max_len_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_cmd       (pop_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
